// ===== hw/rtl/bfa_pkg.sv =====
// bfa_pkg: shared types, constants and codes of the bitmap frame allocator
// used by bfa_controller, bfa_datapath and bitmap_frame_allocator
// no dependencies
`default_nettype none

package bfa_pkg;

    localparam int NUM_FRAMES_DEF      = 8192;
    localparam int RESERVED_FRAMES_DEF = 1024;

    localparam int FRAME_SHIFT = 12;
    localparam int COUNT_W     = 14;
    localparam int ADDR_W      = 25;
    localparam int BYTES_W     = 26;
    localparam int KB_W        = 16;

    localparam logic [KB_W-1:0]    MEMORY_KB_RST = 16'd32768;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 14'h3FFF;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } bfa_op_t;

    typedef struct packed {
        bfa_op_t              opcode;
        logic [BYTES_W-1:0]   request_bytes;
        logic [ADDR_W-1:0]    free_address;
    } bfa_req_t;

    typedef struct packed {
        logic                 success;
        logic [ADDR_W-1:0]    start_address;
        logic [COUNT_W-1:0]   frames_used;
    } bfa_resp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_VERIFY,
        ST_WRITE,
        ST_DONE
    } bfa_state_t;

    // controller to datapath
    typedef struct packed {
        logic init_wr;
        logic load;
        logic scan_begin;
        logic scan_step;
        logic range_begin;
        logic range_step;
        logic commit;
        logic fail;
    } bfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic is_free;
        logic n_zero;
        logic pre_ok;
        logic scan_hit;
        logic scan_end;
        logic fit_ok;
        logic range_empty;
        logic range_done;
    } bfa_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_controller.sv =====
// bfa_controller: sequencing state machine of the frame allocator
// depends on bfa_pkg
`default_nettype none

module bfa_controller
    import bfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire bfa_status_t status,
    output bfa_cmd_t         cmd,
    output logic             busy,
    output logic             done
);

    bfa_state_t state_reg;
    bfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (status.is_free && status.n_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (status.is_free)
                begin
                    state_next = ST_WRITE;
                end
                else if (!status.pre_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (status.scan_hit)
                begin
                    state_next = ST_VERIFY;
                end
                else if (status.scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_VERIFY:
            begin
                state_next = status.fit_ok ? ST_WRITE : ST_DONE;
            end
            ST_WRITE:
            begin
                if (status.range_empty || status.range_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_DONE);
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_CHECK:
            begin
                priority if (status.is_free && status.n_zero)
                begin
                    cmd.commit = 1'b1;
                end
                else if (status.is_free)
                begin
                    cmd.range_begin = 1'b1;
                end
                else if (!status.pre_ok)
                begin
                    cmd.commit = 1'b1;
                    cmd.fail   = 1'b1;
                end
                else
                begin
                    cmd.scan_begin = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end && !status.scan_hit)
                begin
                    cmd.commit = 1'b1;
                    cmd.fail   = 1'b1;
                end
            end
            ST_VERIFY:
            begin
                if (status.fit_ok)
                begin
                    cmd.range_begin = 1'b1;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    cmd.fail   = 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (status.range_empty)
                begin
                    cmd.commit = 1'b1;
                end
                else
                begin
                    cmd.range_step = 1'b1;
                    cmd.commit     = status.range_done;
                end
            end
            ST_DONE:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_datapath.sv =====
// bfa_datapath: bitmap memory, word scanner, range marker and used count
// depends on bfa_pkg; driven by bfa_controller
`default_nettype none

module bfa_datapath
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES      = NUM_FRAMES_DEF,
    parameter int RESERVED_FRAMES = RESERVED_FRAMES_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [KB_W-1:0] cfg_wdata,
    input  wire bfa_req_t        req,
    input  wire bfa_cmd_t        cmd,
    output bfa_status_t          status,
    output bfa_resp_t            resp
);

    localparam int WORDS   = (NUM_FRAMES + 31) / 32;
    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW      = AW + 1;
    localparam int LW      = $clog2(NUM_FRAMES + 1);
    localparam int FW      = ((LW > COUNT_W) ? LW : COUNT_W) + 1;
    localparam int NW      = COUNT_W + 1;
    localparam int RES     = (RESERVED_FRAMES > NUM_FRAMES) ? NUM_FRAMES : RESERVED_FRAMES;
    localparam int RES_CNT = (RES > 16383) ? 16383 : RES;

    localparam logic [PW-1:0]      LAST_WORD = PW'(WORDS - 1);
    localparam logic [PW-1:0]      RES_WORD  = PW'(RES / 32);
    localparam logic [5:0]         RES_BITS  = 6'(RES % 32);
    localparam logic [FW-1:0]      NUM_F     = FW'(NUM_FRAMES);
    localparam logic [COUNT_W-1:0] USED_RST  = COUNT_W'(RES_CNT);

    function automatic logic [5:0] lowest_set(input logic [31:0] v);
        logic [5:0] r;
        r = 6'd32;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] highest_set(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // bitmap store, one bit per frame, set means used
    logic [31:0] bitmap_mem [WORDS];
    logic [31:0] rd_data_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // configuration and request registers
    logic [KB_W-1:0]    memory_kb_reg;
    bfa_op_t            op_reg;
    logic [NW-1:0]      n_reg;
    logic [12:0]        base_reg;
    logic [FW-1:0]      lim_reg;

    logic [BYTES_W:0]   bytes_sum;
    logic [KB_W:0]      kb_sum;
    logic [FW-1:0]      lim_raw;
    logic [FW-1:0]      lim_next;

    assign bytes_sum = {1'b0, req.request_bytes} + (BYTES_W + 1)'(4095);
    assign kb_sum    = {1'b0, memory_kb_reg} + (KB_W + 1)'(3);
    assign lim_raw   = FW'(kb_sum[KB_W:2]);
    assign lim_next  = (lim_raw > NUM_F) ? NUM_F : lim_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_kb_reg <= MEMORY_KB_RST;
        end
        else if (cfg_we)
        begin
            memory_kb_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.opcode;
            n_reg    <= bytes_sum[BYTES_W:FRAME_SHIFT];
            base_reg <= req.free_address[ADDR_W-1:FRAME_SHIFT];
            lim_reg  <= lim_next;
        end
    end

    // used count
    logic [COUNT_W-1:0] used_reg;
    logic [FW-1:0]      need_sum;

    assign need_sum = FW'(used_reg) + FW'(n_reg);

    // clearing pass pointer
    logic [PW-1:0] init_ptr_reg;
    logic [31:0]   init_word;
    logic [32:0]   res_part;

    assign res_part = ~({33{1'b1}} << RES_BITS);

    always_comb
    begin
        if (init_ptr_reg < RES_WORD)
        begin
            init_word = 32'hFFFF_FFFF;
        end
        else if (init_ptr_reg == RES_WORD)
        begin
            init_word = res_part[31:0];
        end
        else
        begin
            init_word = 32'h0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_ptr_reg <= '0;
        end
        else if (cmd.init_wr)
        begin
            init_ptr_reg <= init_ptr_reg + PW'(1);
        end
    end

    // shared word walk: read pointer and the word under evaluation
    logic [PW-1:0] rd_ptr_reg;
    logic          ev_valid_reg;
    logic [PW-1:0] ev_idx_reg;
    logic [FW-1:0] run_reg;
    logic [FW-1:0] start_reg;
    logic [FW-1:0] lo_reg;
    logic [FW-1:0] end_reg;

    // scan evaluation of one word
    logic [31:0]   free_bits;
    logic [5:0]    lead_free;
    logic [4:0]    top_used;
    logic [5:0]    tail_free;
    logic [31:0]   win [6];
    logic [31:0]   fit_bits;
    logic [5:0]    fit_off;
    logic [5:0]    fit_pos;
    logic          n_small;
    logic [PW-1:0] search_words;
    logic          inner_en;
    logic          carried_hit;
    logic          inner_hit;
    logic          hit;
    logic [FW-1:0] word_base;
    logic [FW-1:0] hit_start;
    logic          last_eval;

    assign free_bits    = ~rd_data_reg;
    assign lead_free    = lowest_set(rd_data_reg);
    assign top_used     = highest_set(rd_data_reg);
    assign tail_free    = 6'd31 - {1'b0, top_used};
    assign n_small      = (n_reg <= NW'(32));
    assign search_words = PW'(lim_reg >> 5);
    assign inner_en     = (ev_idx_reg < search_words);
    assign word_base    = FW'({ev_idx_reg, 5'b0});
    assign last_eval    = (ev_idx_reg == search_words) || (ev_idx_reg == LAST_WORD);

    // window of n free bits by doubling erosion
    always_comb
    begin
        win[0]   = free_bits;
        for (int k = 0; k < 5; k++)
        begin
            win[k+1] = win[k] & (win[k] >> (1 << k));
        end
        fit_bits = 32'hFFFF_FFFF;
        fit_off  = 6'd0;
        for (int k = 0; k < 6; k++)
        begin
            if (n_reg[k])
            begin
                fit_bits = fit_bits & (win[k] >> fit_off);
                fit_off  = fit_off + 6'(1 << k);
            end
        end
    end

    assign fit_pos     = lowest_set(fit_bits);
    assign carried_hit = (run_reg != '0) && ((run_reg + FW'(lead_free)) >= FW'(n_reg));
    assign inner_hit   = inner_en && n_small && (fit_bits != 32'h0);
    assign hit         = carried_hit || inner_hit;
    assign hit_start   = carried_hit ? (word_base - run_reg) : (word_base + FW'(fit_pos));

    // range marking of one word
    logic [FW-1:0] lo_calc;
    logic [FW-1:0] end_raw;
    logic [FW-1:0] end_m1;
    logic [PW-1:0] lo_word;
    logic [PW-1:0] end_word;
    logic [4:0]    lo_off;
    logic [5:0]    hi_off;
    logic [32:0]   hi_mask;
    logic [31:0]   range_mask;
    logic [31:0]   marked_word;

    assign lo_calc  = (op_reg == OP_FREE) ? FW'(base_reg) : start_reg;
    assign end_raw  = lo_calc + FW'(n_reg);
    assign end_m1   = end_reg - FW'(1);
    assign lo_word  = PW'(lo_reg >> 5);
    assign end_word = PW'(end_m1 >> 5);
    assign lo_off   = (ev_idx_reg == lo_word) ? lo_reg[4:0] : 5'd0;
    assign hi_off   = (ev_idx_reg == end_word) ? ({1'b0, end_m1[4:0]} + 6'd1) : 6'd32;
    assign hi_mask  = ~({33{1'b1}} << hi_off);
    assign range_mask  = (32'hFFFF_FFFF << lo_off) & hi_mask[31:0];
    assign marked_word = (op_reg == OP_ALLOC) ? (rd_data_reg | range_mask)
                                              : (rd_data_reg & ~range_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (cmd.scan_begin || cmd.range_begin)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step || cmd.range_step)
        begin
            ev_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_begin)
        begin
            rd_ptr_reg <= '0;
            run_reg    <= '0;
        end
        else if (cmd.range_begin)
        begin
            rd_ptr_reg <= PW'(lo_calc >> 5);
            lo_reg     <= lo_calc;
            end_reg    <= (end_raw > NUM_F) ? NUM_F : end_raw;
        end
        else if (cmd.scan_step || cmd.range_step)
        begin
            rd_ptr_reg <= rd_ptr_reg + PW'(1);
            ev_idx_reg <= rd_ptr_reg;
        end
        if (cmd.scan_step && ev_valid_reg)
        begin
            run_reg <= (rd_data_reg == 32'h0) ? (run_reg + FW'(32)) : FW'(tail_free);
            if (hit)
            begin
                start_reg <= hit_start;
            end
        end
    end

    assign rd_en   = (cmd.scan_step || cmd.range_step) && (rd_ptr_reg <= LAST_WORD);
    assign rd_addr = rd_ptr_reg[AW-1:0];
    assign wr_en   = cmd.init_wr || (cmd.range_step && ev_valid_reg);
    assign wr_addr = cmd.init_wr ? init_ptr_reg[AW-1:0] : ev_idx_reg[AW-1:0];
    assign wr_data = cmd.init_wr ? init_word : marked_word;

    // result registers
    logic               success_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [NW-1:0]      add_sum;

    assign add_sum = {1'b0, used_reg} + n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= USED_RST;
        end
        else if (cmd.commit && !cmd.fail)
        begin
            if (op_reg == OP_ALLOC)
            begin
                used_reg <= add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];
            end
            else
            begin
                used_reg <= ({1'b0, used_reg} > n_reg) ? (used_reg - n_reg[COUNT_W-1:0]) : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            success_reg <= !cmd.fail;
            if (!cmd.fail && (op_reg == OP_ALLOC))
            begin
                addr_reg <= {start_reg[12:0], 12'b0};
            end
            else
            begin
                addr_reg <= '0;
            end
        end
    end

    assign resp.success       = success_reg;
    assign resp.start_address = addr_reg;
    assign resp.frames_used   = used_reg;

    assign status.init_done   = (init_ptr_reg == LAST_WORD);
    assign status.is_free     = (op_reg == OP_FREE);
    assign status.n_zero      = (n_reg == '0);
    assign status.pre_ok      = (n_reg != '0) && (need_sum <= lim_reg);
    assign status.scan_hit    = ev_valid_reg && hit;
    assign status.scan_end    = ev_valid_reg && !hit && last_eval;
    assign status.fit_ok      = ((start_reg + FW'(n_reg)) <= lim_reg);
    assign status.range_empty = (lo_reg >= end_reg);
    assign status.range_done  = ev_valid_reg && (ev_idx_reg == end_word);

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: top level of the first-fit page frame allocator
// depends on bfa_pkg, bfa_controller and bfa_datapath
`default_nettype none

// A request beat is taken when start is high and busy is low. Each request
// gives exactly one result beat, shown for a single cycle with done high; the
// receiver cannot stall it, so it must take the result in that cycle. After
// reset the bitmap is swept once, one 32-frame word a cycle with busy high,
// setting the reserved low frames; the memory_kb register may be written at
// any time the block is idle. An allocate walks the bitmap memory one word a
// cycle up to the search limit or the first fit, then marks the run with one
// read-modify-write word a cycle; a free only does the marking walk. No new
// request is taken while busy; the block returns to idle after the result
// beat. The walk speed is set by the single read port of the bitmap memory.

module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES      = NUM_FRAMES_DEF,
    parameter int RESERVED_FRAMES = RESERVED_FRAMES_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    // configuration: memory size in kilobytes
    input  wire logic            cfg_we,
    input  wire logic [KB_W-1:0] cfg_wdata,
    // request beat
    input  wire logic            start,
    input  wire bfa_req_t        req,
    output logic                 busy,
    // result beat
    output logic                 done,
    output bfa_resp_t            resp
);

    // command and status between sequencer and datapath
    bfa_cmd_t    cmd;
    bfa_status_t status;

    bfa_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bfa_datapath #(
        .NUM_FRAMES      (NUM_FRAMES),
        .RESERVED_FRAMES (RESERVED_FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .resp      (resp)
    );

endmodule

`default_nettype wire

// ===== bench/tb_bitmap_frame_allocator.sv =====
// tb_bitmap_frame_allocator: self-checking bench for the first-fit frame allocator
// drives allocate/free beats, predicts each result beat and compares field by field
// depends on bfa_pkg and bitmap_frame_allocator
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int N_FRAMES = NUM_FRAMES_DEF;
    localparam int N_RSV    = RESERVED_FRAMES_DEF;
    localparam int N_WORDS  = (N_FRAMES + 31) / 32;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [KB_W-1:0]   cfg_wdata;
    logic              start;
    bfa_req_t          req;
    logic              busy;
    logic              done;
    bfa_resp_t         resp;

    // pending request beats fed by the stimulus block, drained by the driver
    bfa_req_t          pending_reqs[$];
    // predicted result beats, oldest first
    bfa_resp_t         expected_resps[$];

    // predictor state: own copy of the frame bitmap, count and memory size
    logic [N_FRAMES-1:0] pred_map;
    int unsigned         pred_used;
    int unsigned         pred_kb;

    int                  mismatches;
    int                  driven;
    int                  accepted;
    int                  burst_left;
    int                  gap_left;
    bit                  drain_hold;

    bitmap_frame_allocator #(
        .NUM_FRAMES      (N_FRAMES),
        .RESERVED_FRAMES (N_RSV)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .resp      (resp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // frame lookup; frames past storage read as used
    function automatic bit frame_taken(int unsigned f);
        if (f >= N_FRAMES)
            return 1'b1;
        return pred_map[f];
    endfunction

    // first-fit search over whole words below the limit
    function automatic bit first_fit(int unsigned cnt, int unsigned lim,
                                     output int unsigned run_start);
        int unsigned s;
        int unsigned k;
        int unsigned send;
        send = (lim / 32) * 32;
        s = 0;
        run_start = 0;
        while (s < send)
        begin
            if (frame_taken(s))
            begin
                s++;
                continue;
            end
            if (cnt > lim - s)
                return 1'b0;
            for (k = 1; k < cnt; k++)
                if (frame_taken(s + k))
                    break;
            if (k == cnt)
            begin
                run_start = s;
                return 1'b1;
            end
            s = s + k + 1;
        end
        return 1'b0;
    endfunction

    // apply one request beat to the predictor and return the result it gives
    function automatic bfa_resp_t predict_alloc_result(bfa_req_t r);
        bfa_resp_t   o;
        int unsigned n;
        int unsigned lim;
        int unsigned s;
        int unsigned base;
        n = (int'(r.request_bytes) + 4095) / 4096;
        o = '0;
        if (r.opcode == OP_ALLOC)
        begin
            lim = (pred_kb + 3) / 4;
            if (lim > N_FRAMES)
                lim = N_FRAMES;
            if (n != 0 && pred_used + n <= lim && first_fit(n, lim, s))
            begin
                for (int unsigned k = 0; k < n; k++)
                    if (s + k < N_FRAMES)
                        pred_map[s + k] = 1'b1;
                pred_used += n;
                if (pred_used > 16383)
                    pred_used = 16383;
                o.success       = 1'b1;
                o.start_address = ADDR_W'(s * 4096);
            end
        end
        else
        begin
            base = int'(r.free_address) >> FRAME_SHIFT;
            for (int unsigned k = 0; k < n; k++)
                if (base + k < N_FRAMES)
                    pred_map[base + k] = 1'b0;
            pred_used = (pred_used > n) ? pred_used - n : 0;
            o.success = 1'b1;
        end
        o.frames_used = COUNT_W'(pred_used);
        return o;
    endfunction

    // driver: bursts with random gaps, holds off entirely while draining
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // a beat moves at this edge when start is high and busy low
            if (start && !busy)
            begin
                expected_resps.push_back(predict_alloc_result(req));
                accepted = accepted + 1;
            end
            if (start && busy)
            begin
                // hold the beat until taken
            end
            else if (drain_hold || pending_reqs.size() == 0)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
                driven = driven + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor: every done cycle is one result beat, compared with the oldest
    always @(posedge clk)
    begin
        bfa_resp_t want;
        if (rst_n && done)
        begin
            if (expected_resps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", resp);
            end
            else
            begin
                want = expected_resps.pop_front();
                if (resp.success !== want.success
                    || resp.start_address !== want.start_address
                    || resp.frames_used !== want.frames_used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp ok=%0b addr=%h used=%0d got ok=%0b addr=%h used=%0d",
                                 want.success, want.start_address, want.frames_used,
                                 resp.success, resp.start_address, resp.frames_used);
                end
            end
        end
    end

    // wait until every queued and outstanding beat has come back, then settle
    task automatic drain_all();
        while (pending_reqs.size() != 0 || start || busy || expected_resps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // memory size write while idle; predictor follows
    task automatic set_memory_kb(int unsigned kb);
        drain_all();
        cfg_we    <= 1'b1;
        cfg_wdata <= KB_W'(kb);
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_kb = kb;
    endtask

    function automatic bfa_req_t make_req(bfa_op_t op, int unsigned bytes, int unsigned addr);
        bfa_req_t r;
        r.opcode        = op;
        r.request_bytes = BYTES_W'(bytes);
        r.free_address  = ADDR_W'(addr);
        return r;
    endfunction

    // mostly small sizes, a few large; frees mostly at frame boundaries
    function automatic bfa_req_t random_req();
        int unsigned sel;
        int unsigned bytes;
        int unsigned addr;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            bytes = $urandom_range(1, 16 * 4096);
        else if (sel < 90)
            bytes = $urandom_range(0, 256 * 4096);
        else if (sel < 95)
            bytes = $urandom_range(0, 33554432);
        else
            bytes = $urandom() & 32'h3FF_FFFF;
        if ($urandom_range(0, 3) == 0)
            addr = $urandom() & 32'h1FF_FFFF;
        else
            addr = $urandom_range(0, N_FRAMES - 1) * 4096;
        return make_req(($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE, bytes, addr);
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        mismatches = 0;
        driven     = 0;
        accepted   = 0;
        drain_hold = 1'b0;
        pred_map   = '0;
        for (int f = 0; f < N_RSV && f < N_FRAMES; f++)
            pred_map[f] = 1'b1;
        pred_used = (N_RSV > N_FRAMES) ? N_FRAMES : N_RSV;
        pred_kb   = MEMORY_KB_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero size, tiny, partial frame, extremes, free of free frames
        set_memory_kb(32768);
        pending_reqs.push_back(make_req(OP_ALLOC, 0, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 32'h1FF_FFFF));
        pending_reqs.push_back(make_req(OP_ALLOC, 4096, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 4097, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 33554432, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 32'h3FF_FFFF, 0));
        pending_reqs.push_back(make_req(OP_FREE, 0, 0));
        pending_reqs.push_back(make_req(OP_FREE, 8192, 32'h1FF_FFFF));
        pending_reqs.push_back(make_req(OP_FREE, 40960, 32'h100_0000));
        pending_reqs.push_back(make_req(OP_ALLOC, 7000 * 4096, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 300 * 4096, 0));
        pending_reqs.push_back(make_req(OP_FREE, 32'h3FF_FFFF, 0));
        pending_reqs.push_back(make_req(OP_FREE, 4096, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 8192 * 4096, 0));
        drain_all();
        // restore the reserved-like low region and try small and odd limits
        pending_reqs.push_back(make_req(OP_ALLOC, 1024 * 4096, 0));
        set_memory_kb(0);
        pending_reqs.push_back(make_req(OP_ALLOC, 4096, 0));
        set_memory_kb(4098);
        pending_reqs.push_back(make_req(OP_ALLOC, 4096, 0));
        pending_reqs.push_back(make_req(OP_FREE, 8192 * 4096, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 1000 * 4096, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 25 * 4096, 0));
        set_memory_kb(16'hFFFF);

        // random phases across several memory sizes; one full drain pause each
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: set_memory_kb($urandom_range(1, 4000));
                2: set_memory_kb(32768);
                3: set_memory_kb($urandom_range(4000, 32767));
                4: set_memory_kb(16'hFFFF);
                5: set_memory_kb($urandom() & 16'hFFFF);
                default: ;
            endcase
            for (int i = 0; i < 190; i++)
                pending_reqs.push_back(random_req());
            // let half go, then pause the sender until everything is back
            while (pending_reqs.size() > 95)
                @(posedge clk);
            drain_hold = 1'b1;
            while (start || busy || expected_resps.size() != 0)
                @(posedge clk);
            drain_hold = 1'b0;
        end

        drain_all();
        repeat (600) @(posedge clk);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog well past the slowest correct run
    initial
    begin
        #80ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
